@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PFNT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PFNT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pfnt_pkg.sv @@
// Package: shared types, widths and Q8.24 arithmetic helpers.
`timescale 1ns / 1ps

package pfnt_pkg;

   localparam int DATA_W      = 32;
   localparam int TS_W        = 31;
   localparam int REQ_TDATA_W = 9 * DATA_W;
   localparam int RSP_TDATA_W = 2 * DATA_W;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_STAGES  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DENSITY_GAIN    = 3'd0,
      REG_CUBIC_GAIN      = 3'd1,
      REG_ADVECT_GAIN_ONE = 3'd2,
      REG_ADVECT_GAIN_TWO = 3'd3,
      REG_TIME_STEP       = 3'd4
   } csr_index_type;

   // first member lands in the highest bits, so density sits at bit 0
   typedef struct packed {
      logic signed [DATA_W-1:0] rand_force_y;
      logic signed [DATA_W-1:0] rand_force_x;
      logic signed [DATA_W-1:0] pol_y_dy;
      logic signed [DATA_W-1:0] pol_x_dy;
      logic signed [DATA_W-1:0] pol_y_dx;
      logic signed [DATA_W-1:0] pol_x_dx;
      logic signed [DATA_W-1:0] pol_y;
      logic signed [DATA_W-1:0] pol_x;
      logic signed [DATA_W-1:0] density;
   } point_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] incr_y;
      logic signed [DATA_W-1:0] incr_x;
   } result_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] density_gain;
      logic signed [DATA_W-1:0] cubic_gain;
      logic signed [DATA_W-1:0] advect_gain_one;
      logic signed [DATA_W-1:0] advect_gain_two;
      logic        [TS_W-1:0]   time_step;
   } cfg_type;

   // per-stage load enables, from the handshake control to the datapath
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
   } pipe_ctl_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'sd2147483647;
      lo = -40'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

   // Round a Q16.48 product to Q8.24: add half an LSB, floor, then clamp
   function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd8388608;
      return sat32(signed'(t[63:24]));
   endfunction

   function automatic logic signed [63:0] smul(input logic signed [DATA_W-1:0] a,
                                               input logic signed [DATA_W-1:0] b);
      return 64'(a) * 64'(b);
   endfunction

endpackage

@@ rtl/pfnt_core.sv @@
// Datapath: eight register stages of multiply, round and saturate.
`timescale 1ns / 1ps

module pfnt_core import pfnt_pkg::*; (
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  cfg_type      cfg,
   input  point_type    pt,
   input  logic         last_in,
   output result_type   res,
   output logic         last_out
);

   // stage 1
   logic signed [63:0]       s1_pxx_ff, s1_pyy_ff, s1_drho_ff;
   logic signed [DATA_W-1:0] s1_dmm_ff, s1_dpp_ff, s1_cpp_ff, s1_cmm_ff;
   logic signed [DATA_W-1:0] s1_px_ff, s1_py_ff, s1_rfx_ff, s1_rfy_ff;
   logic                     s1_last_ff;
   // stage 2
   logic signed [DATA_W-1:0] s2_psq_ff, s2_drho_ff;
   logic signed [63:0]       s2_m_ff [8];
   logic signed [DATA_W-1:0] s2_px_ff, s2_py_ff, s2_rfx_ff, s2_rfy_ff;
   logic                     s2_last_ff;
   // stage 3
   logic signed [63:0]       s3_cub_ff;
   logic signed [DATA_W-1:0] s3_drho_ff, s3_ax_ff, s3_bx_ff, s3_ay_ff, s3_by_ff;
   logic signed [DATA_W-1:0] s3_px_ff, s3_py_ff, s3_rfx_ff, s3_rfy_ff;
   logic                     s3_last_ff;
   // stage 4
   logic signed [DATA_W-1:0] s4_g_ff;
   logic signed [63:0]       s4_k_ff [4];
   logic signed [DATA_W-1:0] s4_px_ff, s4_py_ff, s4_rfx_ff, s4_rfy_ff;
   logic                     s4_last_ff;
   // stage 5
   logic signed [63:0]       s5_gx_ff, s5_gy_ff;
   logic signed [DATA_W-1:0] s5_t_ff [4];
   logic signed [DATA_W-1:0] s5_rfx_ff, s5_rfy_ff;
   logic                     s5_last_ff;
   // stage 6
   logic signed [DATA_W-1:0] s6_sx_ff, s6_sy_ff;
   logic                     s6_last_ff;
   // stage 7
   logic signed [63:0]       s7_ix_ff, s7_iy_ff;
   logic                     s7_last_ff;
   // stage 8
   result_type               s8_res_ff;
   logic                     s8_last_ff;

   logic signed [DATA_W-1:0] ts_s;

   assign ts_s = signed'({1'b0, cfg.time_step});

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         s1_pxx_ff  <= smul(pt.pol_x, pt.pol_x);
         s1_pyy_ff  <= smul(pt.pol_y, pt.pol_y);
         s1_drho_ff <= smul(cfg.density_gain, pt.density);
         s1_dmm_ff  <= sat32(40'(pt.pol_x_dx) - 40'(pt.pol_y_dy));
         s1_dpp_ff  <= sat32(40'(pt.pol_x_dx) + 40'(pt.pol_y_dy));
         s1_cpp_ff  <= sat32(40'(pt.pol_y_dx) + 40'(pt.pol_x_dy));
         s1_cmm_ff  <= sat32(40'(pt.pol_y_dx) - 40'(pt.pol_x_dy));
         s1_px_ff   <= pt.pol_x;
         s1_py_ff   <= pt.pol_y;
         s1_rfx_ff  <= pt.rand_force_x;
         s1_rfy_ff  <= pt.rand_force_y;
         s1_last_ff <= last_in;
      end

      if (ctl.adv[1]) begin
         s2_psq_ff  <= sat32(40'(round_sat(s1_pxx_ff)) + 40'(round_sat(s1_pyy_ff)));
         s2_drho_ff <= round_sat(s1_drho_ff);
         s2_m_ff[0] <= smul(s1_px_ff, s1_dmm_ff);
         s2_m_ff[1] <= smul(s1_py_ff, s1_cpp_ff);
         s2_m_ff[2] <= smul(s1_px_ff, s1_dpp_ff);
         s2_m_ff[3] <= smul(s1_py_ff, s1_cmm_ff);
         s2_m_ff[4] <= smul(s1_px_ff, s1_cpp_ff);
         s2_m_ff[5] <= smul(s1_py_ff, s1_dmm_ff);
         s2_m_ff[6] <= smul(s1_px_ff, s1_cmm_ff);
         s2_m_ff[7] <= smul(s1_py_ff, s1_dpp_ff);
         s2_px_ff   <= s1_px_ff;
         s2_py_ff   <= s1_py_ff;
         s2_rfx_ff  <= s1_rfx_ff;
         s2_rfy_ff  <= s1_rfy_ff;
         s2_last_ff <= s1_last_ff;
      end

      if (ctl.adv[2]) begin
         s3_cub_ff  <= smul(cfg.cubic_gain, s2_psq_ff);
         s3_drho_ff <= s2_drho_ff;
         s3_ax_ff   <= sat32(40'(round_sat(s2_m_ff[0])) + 40'(round_sat(s2_m_ff[1])));
         s3_bx_ff   <= sat32(40'(round_sat(s2_m_ff[2])) - 40'(round_sat(s2_m_ff[3])));
         s3_ay_ff   <= sat32(40'(round_sat(s2_m_ff[4])) - 40'(round_sat(s2_m_ff[5])));
         s3_by_ff   <= sat32(40'(round_sat(s2_m_ff[6])) + 40'(round_sat(s2_m_ff[7])));
         s3_px_ff   <= s2_px_ff;
         s3_py_ff   <= s2_py_ff;
         s3_rfx_ff  <= s2_rfx_ff;
         s3_rfy_ff  <= s2_rfy_ff;
         s3_last_ff <= s2_last_ff;
      end

      if (ctl.adv[3]) begin
         s4_g_ff    <= sat32(40'(s3_drho_ff) - 40'(round_sat(s3_cub_ff)));
         s4_k_ff[0] <= smul(cfg.advect_gain_one, s3_ax_ff);
         s4_k_ff[1] <= smul(cfg.advect_gain_two, s3_bx_ff);
         s4_k_ff[2] <= smul(cfg.advect_gain_one, s3_ay_ff);
         s4_k_ff[3] <= smul(cfg.advect_gain_two, s3_by_ff);
         s4_px_ff   <= s3_px_ff;
         s4_py_ff   <= s3_py_ff;
         s4_rfx_ff  <= s3_rfx_ff;
         s4_rfy_ff  <= s3_rfy_ff;
         s4_last_ff <= s3_last_ff;
      end

      if (ctl.adv[4]) begin
         s5_gx_ff   <= smul(s4_g_ff, s4_px_ff);
         s5_gy_ff   <= smul(s4_g_ff, s4_py_ff);
         for (int i = 0; i < 4; i++) begin
            s5_t_ff[i] <= round_sat(s4_k_ff[i]);
         end
         s5_rfx_ff  <= s4_rfx_ff;
         s5_rfy_ff  <= s4_rfy_ff;
         s5_last_ff <= s4_last_ff;
      end

      // second coupling term enters doubled
      if (ctl.adv[5]) begin
         s6_sx_ff   <= sat32(40'(round_sat(s5_gx_ff)) + 40'(s5_t_ff[0])
                             + (40'(s5_t_ff[1]) <<< 1) + 40'(s5_rfx_ff));
         s6_sy_ff   <= sat32(40'(round_sat(s5_gy_ff)) + 40'(s5_t_ff[2])
                             + (40'(s5_t_ff[3]) <<< 1) + 40'(s5_rfy_ff));
         s6_last_ff <= s5_last_ff;
      end

      if (ctl.adv[6]) begin
         s7_ix_ff   <= smul(ts_s, s6_sx_ff);
         s7_iy_ff   <= smul(ts_s, s6_sy_ff);
         s7_last_ff <= s6_last_ff;
      end

      if (ctl.adv[7]) begin
         s8_res_ff.incr_x <= round_sat(s7_ix_ff);
         s8_res_ff.incr_y <= round_sat(s7_iy_ff);
         s8_last_ff       <= s7_last_ff;
      end
   end

   assign res      = s8_res_ff;
   assign last_out = s8_last_ff;

endmodule

@@ rtl/polar_field_nonlinear_term.sv @@
// A request transaction accepted by the pipeline passes through every stage register
// before rsp_tvalid rises and its result can be taken.
// Throughput: one grid point per cycle while rsp is not stalled; each of the eight stages holds one
// point and loads whenever it is empty or the stage after it moves on.
// A stalled rsp side backs up only as far as the pipeline is full.
// Reset (synchronous, active high) empties the pipeline and clears all gains.
`timescale 1ns / 1ps

module polar_field_nonlinear_term import pfnt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, low bit up: density, pol_x, pol_y, pol_x_dx, pol_y_dx,
   // pol_x_dy, pol_y_dy, rand_force_x, rand_force_y
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rsp_tdata, low bit up: incr_x, incr_y
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   cfg_type               cfg_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   pipe_ctl_type          ctl;
   result_type            res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DENSITY_GAIN:    cfg_ff.density_gain    <= signed'(csr_wdata);
            REG_CUBIC_GAIN:      cfg_ff.cubic_gain      <= signed'(csr_wdata);
            REG_ADVECT_GAIN_ONE: cfg_ff.advect_gain_one <= signed'(csr_wdata);
            REG_ADVECT_GAIN_TWO: cfg_ff.advect_gain_two <= signed'(csr_wdata);
            REG_TIME_STEP:       cfg_ff.time_step       <= csr_wdata[TS_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage may load when empty or when its contents move on
   always_comb begin
      ctl.adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ctl.adv[k] = !valid_ff[k] || ctl.adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ctl.adv[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (ctl.adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   pfnt_core u_core (
      .clock    (clock),
      .ctl      (ctl),
      .cfg      (cfg_ff),
      .pt       (point_type'(req_tdata)),
      .last_in  (req_tlast),
      .res      (res),
      .last_out (rsp_tlast)
   );

   assign req_tready = ctl.adv[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = RSP_TDATA_W'(res);

endmodule

@@ rtl/pfnt_checker.sv @@
// Port-level checker for the top level, attached by bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfnt_checker import pfnt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready
);

   // a stalled result transaction holds its payload
   `PFNT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed while stalled")

   // pipeline comes out of reset empty
   `PFNT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   // an empty output stage never holds back the request side
   `PFNT_ASSERT(a_empty_ready, clock, reset, !rsp_tvalid |-> req_tready, "req_tready low with empty output")

   // a draining output lets the whole pipeline move
   `PFNT_ASSERT(a_drain_ready, clock, reset, rsp_tready |-> req_tready, "req_tready low while rsp_tready high")

endmodule

bind polar_field_nonlinear_term pfnt_checker u_pfnt_checker (.*);

@@ tb/polar_field_checker.sv @@
// Checker: predicts polarization increments per grid point and compares the rsp stream.
`timescale 1ns / 1ps

module polar_field_checker import pfnt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count
);

   localparam longint Q_MAX   = 64'sd2147483647;
   localparam longint Q_MIN   = -64'sd2147483648;
   localparam longint Q_HALF  = 64'sd8388608;
   localparam int     Q_SHIFT = 24;
   localparam int     PRINT_CAP = 30;

   typedef struct {
      logic signed [DATA_W-1:0] incr_x;
      logic signed [DATA_W-1:0] incr_y;
      logic                     sweep_end;
   } increment_pair_type;

   // gain mirror, follows every csr transaction
   logic signed [DATA_W-1:0] gain_density;
   logic signed [DATA_W-1:0] gain_cubic;
   logic signed [DATA_W-1:0] gain_advect_one;
   logic signed [DATA_W-1:0] gain_advect_two;
   logic        [TS_W-1:0]   step_size;

   increment_pair_type expected_increments[$];
   increment_pair_type want;
   result_type         got;
   int                 mismatches = 0;
   int                 results_seen = 0;

   function automatic longint widen(input logic signed [DATA_W-1:0] v);
      return v;
   endfunction

   function automatic longint clamp_q24(input longint v);
      if (v > Q_MAX) begin
         return Q_MAX;
      end
      if (v < Q_MIN) begin
         return Q_MIN;
      end
      return v;
   endfunction

   // full product, add half an LSB, floor shift, clamp
   function automatic longint mul_q24(input longint a, input longint b);
      longint prod;
      prod = a * b + Q_HALF;
      return clamp_q24(prod >>> Q_SHIFT);
   endfunction

   function automatic increment_pair_type increments_for_point(input point_type pt,
                                                               input logic last);
      longint px, py, pxx, pyx, pxy, pyy;
      longint psq, dmm, dpp, cpp, cmm, growth;
      longint ax, bx, ay, by, sx, sy, k1, k2, dt;
      increment_pair_type r;
      px  = widen(pt.pol_x);
      py  = widen(pt.pol_y);
      pxx = widen(pt.pol_x_dx);
      pyx = widen(pt.pol_y_dx);
      pxy = widen(pt.pol_x_dy);
      pyy = widen(pt.pol_y_dy);
      k1  = widen(gain_advect_one);
      k2  = widen(gain_advect_two);
      dt  = longint'(step_size);
      psq = clamp_q24(mul_q24(px, px) + mul_q24(py, py));
      dmm = clamp_q24(pxx - pyy);
      dpp = clamp_q24(pxx + pyy);
      cpp = clamp_q24(pyx + pxy);
      cmm = clamp_q24(pyx - pxy);
      growth = clamp_q24(mul_q24(widen(gain_density), widen(pt.density))
                         - mul_q24(widen(gain_cubic), psq));
      ax = clamp_q24(mul_q24(px, dmm) + mul_q24(py, cpp));
      bx = clamp_q24(mul_q24(px, dpp) - mul_q24(py, cmm));
      ay = clamp_q24(mul_q24(px, cpp) - mul_q24(py, dmm));
      by = clamp_q24(mul_q24(px, cmm) + mul_q24(py, dpp));
      sx = clamp_q24(mul_q24(growth, px) + mul_q24(k1, ax) + 2 * mul_q24(k2, bx)
                     + widen(pt.rand_force_x));
      sy = clamp_q24(mul_q24(growth, py) + mul_q24(k1, ay) + 2 * mul_q24(k2, by)
                     + widen(pt.rand_force_y));
      r.incr_x    = DATA_W'(mul_q24(dt, sx));
      r.incr_y    = DATA_W'(mul_q24(dt, sy));
      r.sweep_end = last;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint seen, input longint wanted);
      if (mismatches < PRINT_CAP) begin
         $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, seen, wanted);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_increments.delete();
         gain_density    <= '0;
         gain_cubic      <= '0;
         gain_advect_one <= '0;
         gain_advect_two <= '0;
         step_size       <= '0;
      end else begin
         // rsp first: a point accepted on this edge cannot be the source
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata);
            results_seen++;
            if (expected_increments.size() == 0) begin
               report_mismatch("rsp transaction with nothing pending, incr_x",
                               widen(got.incr_x), 0);
            end else begin
               want = expected_increments.pop_front();
               if (got.incr_x !== want.incr_x) begin
                  report_mismatch("incr_x", widen(got.incr_x), widen(want.incr_x));
               end
               if (got.incr_y !== want.incr_y) begin
                  report_mismatch("incr_y", widen(got.incr_y), widen(want.incr_y));
               end
               if (rsp_tlast !== want.sweep_end) begin
                  report_mismatch("sweep_end", longint'(rsp_tlast), longint'(want.sweep_end));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_increments.push_back(increments_for_point(point_type'(req_tdata),
                                                               req_tlast));
         end
         if (csr_we) begin
            case (csr_index)
               REG_DENSITY_GAIN:    gain_density    <= csr_wdata;
               REG_CUBIC_GAIN:      gain_cubic      <= csr_wdata;
               REG_ADVECT_GAIN_ONE: gain_advect_one <= csr_wdata;
               REG_ADVECT_GAIN_TWO: gain_advect_two <= csr_wdata;
               REG_TIME_STEP:       step_size       <= csr_wdata[TS_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_increments.size();
      fail_count    <= mismatches;
      checked_count <= results_seen;
   end

endmodule

@@ tb/tb_polar_field_nonlinear_term.sv @@
// Testbench top: clock, reset, gain settings, grid point stream and verdict.
`timescale 1ns / 1ps

module tb_polar_field_nonlinear_term;
   import pfnt_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int NUM_REGS         = 5;
   localparam int RANDOM_PHASES    = 8;
   localparam int POINTS_PER_PHASE = 210;
   localparam int DRAIN_CYCLES     = NUM_STAGES + 4;

   localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] Q_ONE  = 32'h0100_0000;
   localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [DATA_W-1:0]      csr_wdata  = '0;

   int mismatch_total;
   int increments_pending;
   int increments_checked;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int points_sent     = 0;
   int settings_applied = 0;
   int cycle_count     = 0;

   polar_field_nonlinear_term DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   polar_field_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (mismatch_total),
      .pending_count (increments_pending),
      .checked_count (increments_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, increments_pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // mostly moderate magnitudes so the arithmetic stays out of saturation
   function automatic logic [DATA_W-1:0] random_q24();
      logic [DATA_W-1:0] corner[7];
      int unsigned pick;
      corner = '{Q_MAX, Q_MIN, Q_ZERO, 32'h1, 32'hFFFF_FFFF, Q_ONE, 32'hFF00_0000};
      pick = $urandom_range(99);
      if (pick < 60) begin
         return $urandom_range(32'h0800_0000) - 32'h0400_0000;
      end else if (pick < 85) begin
         return $urandom;
      end
      return corner[$urandom_range(6)];
   endfunction

   function automatic logic [DATA_W-1:0] random_gain();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      end else if (pick < 80) begin
         return $urandom;
      end
      return ($urandom_range(1) != 0) ? Q_MAX : Q_MIN;
   endfunction

   // bit 31 is random: only the low bits of the time step register are kept
   function automatic logic [DATA_W-1:0] random_step();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return {$urandom_range(1) != 0, 31'($urandom_range(Q_ONE))};
      end else if (pick < 80) begin
         return $urandom;
      end
      return ($urandom_range(1) != 0) ? Q_MAX : 32'hFFFF_FFFF;
   endfunction

   function automatic point_type make_point(
         input logic [DATA_W-1:0] rho, px, py, pxx, pyx, pxy, pyy, rfx, rfy);
      point_type pt;
      pt.density      = rho;
      pt.pol_x        = px;
      pt.pol_y        = py;
      pt.pol_x_dx     = pxx;
      pt.pol_y_dx     = pyx;
      pt.pol_x_dy     = pxy;
      pt.pol_y_dy     = pyy;
      pt.rand_force_x = rfx;
      pt.rand_force_y = rfy;
      return pt;
   endfunction

   function automatic point_type random_point();
      point_type pt;
      pt = make_point(random_q24(), random_q24(), random_q24(), random_q24(), random_q24(),
                      random_q24(), random_q24(), random_q24(), random_q24());
      // ordered variant: no random field
      if ($urandom_range(9) < 3) begin
         pt.rand_force_x = '0;
         pt.rand_force_y = '0;
      end
      return pt;
   endfunction

   task automatic send_point(input point_type pt, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      points_sent++;
   endtask

   // valid drops here; then wait for every result, then a further DRAIN_CYCLES wait
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (increments_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [DATA_W-1:0] dg, cg, a1, a2, ts);
      csr_write(REG_DENSITY_GAIN, dg);
      csr_write(REG_CUBIC_GAIN, cg);
      csr_write(REG_ADVECT_GAIN_ONE, a1);
      csr_write(REG_ADVECT_GAIN_TWO, a2);
      csr_write(REG_TIME_STEP, ts);
      // unmapped indexes must leave the gains alone
      for (int i = NUM_REGS; i < 2 ** CSR_INDEX_W; i++) begin
         csr_write(CSR_INDEX_W'(i), $urandom);
      end
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 71; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  rsp_stall_pct = 71; end
         default:       begin sender_idle_pct = 31; rsp_stall_pct = 31; end
      endcase
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_idle_mode(IDLE_NONE);

      // gains still at their reset value
      send_point(make_point(Q_ONE, Q_ONE, Q_MIN, Q_MAX, Q_ONE, Q_ONE, Q_MIN, Q_MAX, Q_MIN), 1'b0);
      send_point(random_point(), 1'b1);
      send_point(random_point(), 1'b0);
      wait_drained();

      apply_settings(Q_ONE, 32'h0080_0000, 32'h0040_0000, 32'hFF40_0000, {1'b1, 31'(Q_ONE)});
      send_point(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                            Q_ZERO), 1'b0);
      send_point(make_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1);
      send_point(make_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0);
      send_point(make_point(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX), 1'b0);
      // squared magnitude overflows
      send_point(make_point(Q_ZERO, Q_MAX, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                            Q_ZERO), 1'b0);
      // derivative sums and differences overflow
      send_point(make_point(Q_ONE, Q_ONE, Q_ONE, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_ZERO,
                            Q_ZERO), 1'b1);
      // exact halves: positive rounds up, negative rounds toward zero
      send_point(make_point(Q_ZERO, 32'h1000, Q_ZERO, 32'h800, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                            Q_ZERO), 1'b0);
      send_point(make_point(Q_ZERO, 32'hFFFF_F000, Q_ZERO, 32'h800, Q_ZERO, Q_ZERO, Q_ZERO,
                            Q_ZERO, Q_ZERO), 1'b0);
      send_point(make_point(Q_ZERO, Q_ZERO, 32'h1000, Q_ZERO, Q_ZERO, Q_ZERO, 32'hFFFF_F800,
                            Q_ZERO, Q_ZERO), 1'b0);
      // random field alone, both extremes
      send_point(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX,
                            Q_MIN), 1'b0);
      send_point(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN,
                            Q_MAX), 1'b1);
      send_point(make_point(Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                            Q_ZERO), 1'b0);
      send_point(make_point(32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                            32'h1, 32'hFFFF_FFFF, 32'h1), 1'b0);
      send_point(random_point(), 1'b1);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            apply_settings(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
         end else if (phase == 1) begin
            apply_settings(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'hFFFF_FFFF);
         end else begin
            apply_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                           random_step());
         end
         set_idle_mode(idle_mode_type'(phase % 4));
         repeat (POINTS_PER_PHASE) begin
            send_point(random_point(), $urandom_range(15) == 0);
         end
         wait_drained();
      end

      $display("Coverage: %0d grid points, %0d increments checked, %0d gain settings.",
               points_sent, increments_checked, settings_applied);
      $display("Flow control ran free, sender-gapped, rsp-stalled and with both sides idling.");
      if (mismatch_total == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
